@@ hw/rtl/urf_pkg.sv @@
// Shared types and constants for the UART receive/transmit ring FIFO core.
// Holds the command and result word layouts, event codes and FIFO status types.
// Depends on nothing; every other file in hw/rtl imports it.
package urf_pkg;

    localparam int BYTE_W        = 8;
    localparam int FUNC_W        = 3;
    localparam int LEVEL_W       = 8;
    localparam int RX_DEPTH_DEF  = 32;
    localparam int TX_DEPTH_DEF  = 32;

    // Event codes carried in the func field of a command word.
    localparam logic [FUNC_W-1:0] FUNC_RX_BYTE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_START_TX = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TX_EMPTY = 3'd4;

    // One command word.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  rx_data;
        logic               line_send;
        logic [BYTE_W-1:0]  line_byte;
        logic               tx_irq_on;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } result_t;

    // Requests from the core to one ring FIFO.
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    // Status of one ring FIFO, taken from its pointer registers.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } fifo_stat_t;

endpackage

@@ hw/rtl/urf_ring_fifo.sv @@
// Circular byte FIFO that keeps one slot empty, so it holds DEPTH-1 bytes.
// Storage is a memory array with one write and one registered read per cycle.
// Depends on urf_pkg for the control and status structs.
module urf_ring_fifo #(
    parameter int DEPTH = urf_pkg::RX_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  urf_pkg::fifo_ctrl_t        ctrl,
    input  logic [urf_pkg::BYTE_W-1:0] push_data,
    output urf_pkg::fifo_stat_t        stat,
    output logic [urf_pkg::BYTE_W-1:0] rd_data
);
    import urf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W:0]    diff;

    // Pointer increments wrap at the FIFO depth.
    always_comb
    begin
        wr_ptr_inc = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_inc = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        wr_ptr_next = ctrl.push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = ctrl.pop ? rd_ptr_inc : rd_ptr_reg;
    end

    // Occupancy is the pointer distance modulo the depth.
    always_comb
    begin
        diff = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        if (wr_ptr_reg < rd_ptr_reg)
        begin
            diff = diff + (PTR_W + 1)'(DEPTH);
        end
        stat.level = LEVEL_W'(diff);
        stat.empty = (wr_ptr_reg == rd_ptr_reg);
        stat.full  = (wr_ptr_inc == rd_ptr_reg);
    end

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage write and registered read of the oldest word.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/uart_tx_rx_ring_fifo_core.sv @@
// Top level of the UART ring FIFO core: receive and transmit byte FIFOs.
// Instantiates two urf_ring_fifo blocks; types and codes come from urf_pkg.
//
// Usage:
//   A command word (func, data_byte) is taken at a rising edge where start is
//   high and busy is low. busy never rises, so one command per cycle is taken.
//   Each command gives exactly one result word, shown on result for one cycle
//   with done high, in the cycle right after the command was taken; the
//   throughput is one word per cycle. The result comes from
//   the result registers and the registered read port of the FIFO memory
//   touched by the command; each command does at most one FIFO write and one
//   FIFO read. Levels and the interrupt flag in a result show the state just
//   after its command.
//   The receiver cannot hold results off; a result not taken in its cycle is
//   gone. Reset clears both FIFOs' pointers, the transmit interrupt flag and
//   done; FIFO memory contents are not cleared and need no clearing pass.
//   Event codes five to seven change nothing and report ok and line_send low.
module uart_tx_rx_ring_fifo_core #(
    parameter int RX_DEPTH = urf_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urf_pkg::TX_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  urf_pkg::cmd_t    cmd,
    output logic             done,
    output urf_pkg::result_t result
);
    import urf_pkg::*;

    logic       accept;
    fifo_ctrl_t rx_ctrl;
    fifo_ctrl_t tx_ctrl;
    fifo_stat_t rx_stat;
    fifo_stat_t tx_stat;
    logic [BYTE_W-1:0] rx_rd_data;
    logic [BYTE_W-1:0] tx_rd_data;

    logic irq_reg;
    logic irq_next;
    logic done_reg;
    logic ok_reg;
    logic ok_next;
    logic rx_pop_reg;
    logic send_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Decode the event into FIFO requests and the next interrupt flag.
    always_comb
    begin
        rx_ctrl  = '0;
        tx_ctrl  = '0;
        ok_next  = 1'b0;
        irq_next = irq_reg;
        if (accept)
        begin
            case (cmd.func)
                FUNC_RX_BYTE:
                begin
                    rx_ctrl.push = ~rx_stat.full;
                    ok_next      = ~rx_stat.full;
                end
                FUNC_PUT:
                begin
                    tx_ctrl.push = ~tx_stat.full;
                    ok_next      = ~tx_stat.full;
                end
                FUNC_GET:
                begin
                    rx_ctrl.pop = ~rx_stat.empty;
                    ok_next     = ~rx_stat.empty;
                end
                FUNC_START_TX:
                begin
                    if (!irq_reg && !tx_stat.empty)
                    begin
                        tx_ctrl.pop = 1'b1;
                        // Enable the interrupt when bytes remain after this one.
                        irq_next = (tx_stat.level > LEVEL_W'(1));
                    end
                end
                FUNC_TX_EMPTY:
                begin
                    if (!tx_stat.empty)
                    begin
                        tx_ctrl.pop = 1'b1;
                    end
                    else
                    begin
                        irq_next = 1'b0;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Control and result flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_reg    <= 1'b0;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            rx_pop_reg <= 1'b0;
            send_reg   <= 1'b0;
        end
        else
        begin
            irq_reg    <= irq_next;
            done_reg   <= accept;
            ok_reg     <= ok_next;
            rx_pop_reg <= rx_ctrl.pop;
            send_reg   <= tx_ctrl.pop;
        end
    end

    urf_ring_fifo #(
        .DEPTH(RX_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .push_data (cmd.data_byte),
        .stat      (rx_stat),
        .rd_data   (rx_rd_data)
    );

    urf_ring_fifo #(
        .DEPTH(TX_DEPTH)
    ) u_tx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tx_ctrl),
        .push_data (cmd.data_byte),
        .stat      (tx_stat),
        .rd_data   (tx_rd_data)
    );

    // Assemble the result word; bytes read zero when nothing was popped.
    always_comb
    begin
        result.ok        = ok_reg;
        result.rx_data   = rx_pop_reg ? rx_rd_data : '0;
        result.line_send = send_reg;
        result.line_byte = send_reg ? tx_rd_data : '0;
        result.tx_irq_on = irq_reg;
        result.rx_level  = rx_stat.level;
        result.tx_level  = tx_stat.level;
    end

    assign done = done_reg;

endmodule

@@ dv/tb_uart_tx_rx_ring_fifo_core.sv @@
// Self-checking testbench for uart_tx_rx_ring_fifo_core: directed and random event traffic.
// A built-in ring FIFO predictor checks every result word field by field.
// Depends on urf_pkg and the uart_tx_rx_ring_fifo_core RTL.
module tb_uart_tx_rx_ring_fifo_core;
    import urf_pkg::*;

    localparam int RX_DEPTH       = RX_DEPTH_DEF;
    localparam int TX_DEPTH       = TX_DEPTH_DEF;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 360;

    // Highest event code the func field can carry; codes above TX_EMPTY are unused.
    localparam logic [FUNC_W-1:0] FUNC_MAX = {FUNC_W{1'b1}};

    // Traffic shapes for the random part.
    localparam int TRAFFIC_FILL  = 0;
    localparam int TRAFFIC_DRAIN = 1;
    localparam int TRAFFIC_MIXED = 2;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    // Predictor state: both rings, their pointers and the transmit interrupt flag.
    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    int                rx_wr_ptr;
    int                rx_rd_ptr;
    int                tx_wr_ptr;
    int                tx_rd_ptr;
    logic              tx_irq_flag;

    result_t pending_results [$];
    int      error_count;
    int      stall_cycles;
    int      sender_idle_pct;

    uart_tx_rx_ring_fifo_core #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Free-running clock, period of 10.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one event to the predicted FIFO state and returns the word it should give.
    function automatic result_t ring_fifo_step(input cmd_t c);
        result_t r;
        r = '0;
        case (c.func)
            FUNC_RX_BYTE:
            begin
                if ((rx_wr_ptr + 1) % RX_DEPTH != rx_rd_ptr)
                begin
                    rx_ring[rx_wr_ptr] = c.data_byte;
                    rx_wr_ptr = (rx_wr_ptr + 1) % RX_DEPTH;
                    r.ok = 1'b1;
                end
            end
            FUNC_PUT:
            begin
                if ((tx_wr_ptr + 1) % TX_DEPTH != tx_rd_ptr)
                begin
                    tx_ring[tx_wr_ptr] = c.data_byte;
                    tx_wr_ptr = (tx_wr_ptr + 1) % TX_DEPTH;
                    r.ok = 1'b1;
                end
            end
            FUNC_GET:
            begin
                if (rx_rd_ptr != rx_wr_ptr)
                begin
                    r.rx_data = rx_ring[rx_rd_ptr];
                    rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
                    r.ok = 1'b1;
                end
            end
            FUNC_START_TX:
            begin
                // Ignored while the interrupt already drives transmission.
                if (!tx_irq_flag && tx_rd_ptr != tx_wr_ptr)
                begin
                    r.line_byte = tx_ring[tx_rd_ptr];
                    tx_rd_ptr = (tx_rd_ptr + 1) % TX_DEPTH;
                    r.line_send = 1'b1;
                    if (tx_rd_ptr != tx_wr_ptr)
                    begin
                        tx_irq_flag = 1'b1;
                    end
                end
            end
            FUNC_TX_EMPTY:
            begin
                if (tx_rd_ptr != tx_wr_ptr)
                begin
                    r.line_byte = tx_ring[tx_rd_ptr];
                    tx_rd_ptr = (tx_rd_ptr + 1) % TX_DEPTH;
                    r.line_send = 1'b1;
                end
                else
                begin
                    tx_irq_flag = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.tx_irq_on = tx_irq_flag;
        r.rx_level  = LEVEL_W'((rx_wr_ptr + RX_DEPTH - rx_rd_ptr) % RX_DEPTH);
        r.tx_level  = LEVEL_W'((tx_wr_ptr + TX_DEPTH - tx_rd_ptr) % TX_DEPTH);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("mismatch on %s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            end
        end
    endtask

    // Checks each result word against the oldest prediction, then predicts any word taken.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("unexpected result word 0x%h", result);
                    end
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("ok",        BYTE_W'(exp_r.ok),        BYTE_W'(result.ok));
                    check_field("rx_data",   exp_r.rx_data,            result.rx_data);
                    check_field("line_send", BYTE_W'(exp_r.line_send), BYTE_W'(result.line_send));
                    check_field("line_byte", exp_r.line_byte,          result.line_byte);
                    check_field("tx_irq_on", BYTE_W'(exp_r.tx_irq_on), BYTE_W'(result.tx_irq_on));
                    check_field("rx_level",  exp_r.rx_level,           result.rx_level);
                    check_field("tx_level",  exp_r.tx_level,           result.tx_level);
                end
            end
            if (start && !busy)
            begin
                pending_results.push_back(ring_fifo_step(cmd));
            end
        end
    end

    // Ends the run when neither a command nor a result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_uart_tx_rx_ring_fifo_core failed");
            $finish;
        end
    end

    // Sends one command word after a random idle gap; returns at the edge that takes it.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data);
        cmd_t c;
        c.func      = func;
        c.data_byte = data;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted word has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Events on empty FIFOs and the unused codes.
    task automatic test_empty_events();
        logic [FUNC_W-1:0] f;
        send_cmd(FUNC_GET, 8'h00);
        send_cmd(FUNC_START_TX, 8'hFF);
        send_cmd(FUNC_TX_EMPTY, 8'h00);
        for (f = FUNC_TX_EMPTY + 1'b1; f != '0; f++)
        begin
            send_cmd(f, 8'hFF);
        end
    endtask

    // Receive path with extreme byte values, ending in a get on an empty FIFO.
    task automatic test_rx_path();
        send_cmd(FUNC_RX_BYTE, 8'h00);
        send_cmd(FUNC_RX_BYTE, 8'hFF);
        send_cmd(FUNC_RX_BYTE, 8'hA5);
        repeat (4)
        begin
            send_cmd(FUNC_GET, 8'h5A);
        end
    endtask

    // Transmit path: single-byte start, interrupt raised, start ignored, flag cleared.
    task automatic test_tx_path();
        send_cmd(FUNC_PUT, 8'hFF);
        send_cmd(FUNC_START_TX, 8'h00);
        send_cmd(FUNC_PUT, 8'h00);
        send_cmd(FUNC_PUT, 8'h5A);
        send_cmd(FUNC_START_TX, 8'h00);
        send_cmd(FUNC_PUT, 8'h81);
        send_cmd(FUNC_START_TX, 8'h00);
        repeat (3)
        begin
            send_cmd(FUNC_TX_EMPTY, 8'h00);
        end
    endtask

    // Picks an event code for the given traffic shape.
    function automatic logic [FUNC_W-1:0] pick_func(input int shape);
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            return FUNC_W'($urandom_range(FUNC_MAX, FUNC_TX_EMPTY + 1));
        end
        case (shape)
            TRAFFIC_FILL:
            begin
                if (pick < 50)      return FUNC_RX_BYTE;
                else if (pick < 90) return FUNC_PUT;
                else if (pick < 94) return FUNC_GET;
                else if (pick < 97) return FUNC_START_TX;
                else                return FUNC_TX_EMPTY;
            end
            TRAFFIC_DRAIN:
            begin
                if (pick < 45)      return FUNC_GET;
                else if (pick < 80) return FUNC_TX_EMPTY;
                else if (pick < 93) return FUNC_START_TX;
                else if (pick < 97) return FUNC_RX_BYTE;
                else                return FUNC_PUT;
            end
            default:
            begin
                return FUNC_W'($urandom_range(FUNC_TX_EMPTY, FUNC_RX_BYTE));
            end
        endcase
    endfunction

    // Bursts of fill, drain and mixed traffic so both FIFOs reach full and empty often.
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int sent;
        int burst_left;
        int shape;
        sent            = 0;
        burst_left      = 0;
        shape           = TRAFFIC_MIXED;
        sender_idle_pct = idle_pct;
        while (sent < n_items)
        begin
            if (burst_left == 0)
            begin
                shape      = $urandom_range(TRAFFIC_MIXED, TRAFFIC_FILL);
                burst_left = $urandom_range(90, 30);
            end
            send_cmd(pick_func(shape), BYTE_W'($urandom_range(255)));
            burst_left--;
            sent++;
        end
    endtask

    initial
    begin
        start           <= 1'b0;
        cmd             <= '0;
        rst_n           <= 1'b0;
        error_count     = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        rx_wr_ptr       = 0;
        rx_rd_ptr       = 0;
        tx_wr_ptr       = 0;
        tx_rd_ptr       = 0;
        tx_irq_flag     = 1'b0;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        test_empty_events();
        test_rx_path();
        test_tx_path();
        drain_results();

        // Random part through the idle phases.
        test_random_traffic(PHASE_ITEMS, 0);
        test_random_traffic(PHASE_ITEMS, 69);
        drain_results();
        test_random_traffic(PHASE_ITEMS, 30);
        test_random_traffic(PHASE_ITEMS, 0);

        // Let the last words come back, then allow a few quiet cycles.
        drain_results();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("tb_uart_tx_rx_ring_fifo_core passed");
        end
        else
        begin
            $display("tb_uart_tx_rx_ring_fifo_core failed");
        end
        $finish;
    end

endmodule
